// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL that checks itself.
// Expects clk and rst (synchronous, active high) in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked during reset.
`define WSM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, masked during reset.
`define WSM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hw/rtl/wsm_pkg.sv
// Shared widths, register indexes and lane types for the wheel slip monitor.
// No dependencies.
package wsm_pkg;

  localparam int SPEED_BITS = 12;
  localparam int NUM_WHEELS = 4;
  localparam int SUM_BITS   = SPEED_BITS + 2;
  localparam int DIFF_BITS  = SUM_BITS + 1;
  localparam int PCT_BITS   = 7;
  localparam int MIN_BITS   = 12;
  localparam int THR_BITS   = SUM_BITS + PCT_BITS;
  localparam int PROD_BITS  = THR_BITS + 2;
  localparam int CNT_BITS   = 32;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 12;
  localparam int PCT_SCALE  = 100;

  localparam logic [CFG_IDX_BITS-1:0] REG_ABS_ENABLE    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_TCS_ENABLE    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_ABS_MIN_SPEED = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_TCS_MIN_SPEED = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_ABS_SLIP_PCT  = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_TCS_SLIP_PCT  = 3'd5;

  localparam logic [MIN_BITS-1:0] ABS_MIN_SPEED_RST = 12'd100;
  localparam logic [MIN_BITS-1:0] TCS_MIN_SPEED_RST = 12'd30;
  localparam logic [PCT_BITS-1:0] ABS_SLIP_PCT_RST  = 7'd15;
  localparam logic [PCT_BITS-1:0] TCS_SLIP_PCT_RST  = 7'd15;

  typedef struct packed {
    logic abs_hit;
    logic tcs_hit;
  } lane_flags_t;

  typedef struct packed {
    logic [NUM_WHEELS-1:0] abs_mask;
    logic [NUM_WHEELS-1:0] tcs_mask;
    logic [CNT_BITS-1:0]   abs_cnt_next;
    logic [CNT_BITS-1:0]   tcs_cnt_next;
  } merge_res_t;

endpackage

// File: hw/rtl/wsm_lane.sv
// One wheel lane: cross-multiplied slip compare for lock and spin.
// Depends on wsm_pkg.
module wsm_lane (
  input  logic [wsm_pkg::SPEED_BITS-1:0] speed,
  input  logic [wsm_pkg::SUM_BITS-1:0]   sum,
  input  logic [wsm_pkg::THR_BITS-1:0]   abs_thr,
  input  logic [wsm_pkg::THR_BITS-1:0]   tcs_thr,
  output wsm_pkg::lane_flags_t           flags
);

  logic signed [wsm_pkg::DIFF_BITS-1:0] diff;
  logic signed [wsm_pkg::PROD_BITS-1:0] diff_x;
  logic signed [wsm_pkg::PROD_BITS-1:0] scaled;
  logic signed [wsm_pkg::PROD_BITS-1:0] scaled_neg;
  logic signed [wsm_pkg::PROD_BITS-1:0] abs_thr_x;
  logic signed [wsm_pkg::PROD_BITS-1:0] tcs_thr_x;

  // diff = sum - 4*speed, i.e. 4 * (average - speed)
  assign diff       = $signed({1'b0, sum}) - $signed({1'b0, speed, 2'b00});
  assign diff_x     = wsm_pkg::PROD_BITS'(diff);
  assign scaled     = diff_x * $signed(wsm_pkg::PROD_BITS'(wsm_pkg::PCT_SCALE));
  assign scaled_neg = -scaled;
  assign abs_thr_x  = $signed({2'b00, abs_thr});
  assign tcs_thr_x  = $signed({2'b00, tcs_thr});

  assign flags.abs_hit = scaled > abs_thr_x;
  assign flags.tcs_hit = scaled_neg > tcs_thr_x;

endmodule

// File: hw/rtl/wsm_merge.sv
// Merge stage: gathers lane flags into wheel masks and next event counts.
// Depends on wsm_pkg.
module wsm_merge (
  input  wsm_pkg::lane_flags_t            flags [wsm_pkg::NUM_WHEELS],
  input  logic                            abs_on,
  input  logic                            tcs_on,
  input  logic [wsm_pkg::CNT_BITS-1:0]    abs_cnt,
  input  logic [wsm_pkg::CNT_BITS-1:0]    tcs_cnt,
  output wsm_pkg::merge_res_t             res
);

  logic [wsm_pkg::NUM_WHEELS-1:0] abs_raw;
  logic [wsm_pkg::NUM_WHEELS-1:0] tcs_raw;

  always_comb begin
    for (int i = 0; i < wsm_pkg::NUM_WHEELS; i++) begin
      abs_raw[i] = flags[i].abs_hit;
      tcs_raw[i] = flags[i].tcs_hit;
    end
  end

  // a check that is off or below its minimum speed reports nothing
  assign res.abs_mask = abs_on ? abs_raw : '0;
  assign res.tcs_mask = tcs_on ? tcs_raw : '0;
  assign res.abs_cnt_next = (|res.abs_mask) ? abs_cnt + wsm_pkg::CNT_BITS'(1) : abs_cnt;
  assign res.tcs_cnt_next = (|res.tcs_mask) ? tcs_cnt + wsm_pkg::CNT_BITS'(1) : tcs_cnt;

endmodule

// File: hw/rtl/wheel_slip_monitor_top.sv
// Wheel slip monitor: four speed lanes in parallel, merged into ABS/TCS flags.
// Two register stages; the result word is registered in the output stage behind stage 1
// and is held there while out_ready is low.
// Throughput: one word per cycle while out_ready is high; in_ready follows out_ready through the
// two-stage pipe (sum/gate stage, then lane compare and merge into the output).
// Reset (rst, synchronous): pipe empty, counters zero, registers at defaults.
// Depends on wsm_pkg, wsm_lane, wsm_merge and assert_macros.svh.
`include "assert_macros.svh"

module wheel_slip_monitor_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [wsm_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [wsm_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [wsm_pkg::SPEED_BITS-1:0]       speed_front_left,
  input  logic [wsm_pkg::SPEED_BITS-1:0]       speed_front_right,
  input  logic [wsm_pkg::SPEED_BITS-1:0]       speed_rear_left,
  input  logic [wsm_pkg::SPEED_BITS-1:0]       speed_rear_right,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 lock_flag,
  output logic [wsm_pkg::NUM_WHEELS-1:0]       lock_wheels,
  output logic                                 spin_flag,
  output logic [wsm_pkg::NUM_WHEELS-1:0]       spin_wheels,
  output logic [wsm_pkg::CNT_BITS-1:0]         abs_events,
  output logic [wsm_pkg::CNT_BITS-1:0]         tcs_events
);

  // configuration registers
  logic                              abs_enable;
  logic                              tcs_enable;
  logic [wsm_pkg::MIN_BITS-1:0]      abs_min_speed;
  logic [wsm_pkg::MIN_BITS-1:0]      tcs_min_speed;
  logic [wsm_pkg::PCT_BITS-1:0]      abs_slip_pct;
  logic [wsm_pkg::PCT_BITS-1:0]      tcs_slip_pct;

  always_ff @(posedge clk) begin
    if (rst) begin
      abs_enable    <= 1'b1;
      tcs_enable    <= 1'b1;
      abs_min_speed <= wsm_pkg::ABS_MIN_SPEED_RST;
      tcs_min_speed <= wsm_pkg::TCS_MIN_SPEED_RST;
      abs_slip_pct  <= wsm_pkg::ABS_SLIP_PCT_RST;
      tcs_slip_pct  <= wsm_pkg::TCS_SLIP_PCT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wsm_pkg::REG_ABS_ENABLE:    abs_enable    <= cfg_data[0];
        wsm_pkg::REG_TCS_ENABLE:    tcs_enable    <= cfg_data[0];
        wsm_pkg::REG_ABS_MIN_SPEED: abs_min_speed <= cfg_data[wsm_pkg::MIN_BITS-1:0];
        wsm_pkg::REG_TCS_MIN_SPEED: tcs_min_speed <= cfg_data[wsm_pkg::MIN_BITS-1:0];
        wsm_pkg::REG_ABS_SLIP_PCT:  abs_slip_pct  <= cfg_data[wsm_pkg::PCT_BITS-1:0];
        wsm_pkg::REG_TCS_SLIP_PCT:  tcs_slip_pct  <= cfg_data[wsm_pkg::PCT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // pipe control
  logic s1_valid;
  logic out_load;
  logic in_take;

  assign out_load = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || out_load;
  assign in_take  = in_valid && in_ready;

  // stage 1: sum and speed gating
  logic [wsm_pkg::SUM_BITS-1:0]   sum_in;
  logic [wsm_pkg::SUM_BITS-1:0]   s1_sum;
  logic [wsm_pkg::SPEED_BITS-1:0] s1_speed [wsm_pkg::NUM_WHEELS];
  logic                           s1_abs_on;
  logic                           s1_tcs_on;

  assign sum_in = wsm_pkg::SUM_BITS'(speed_front_left) + wsm_pkg::SUM_BITS'(speed_front_right)
                + wsm_pkg::SUM_BITS'(speed_rear_left) + wsm_pkg::SUM_BITS'(speed_rear_right);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_sum      <= sum_in;
      s1_speed[0] <= speed_front_left;
      s1_speed[1] <= speed_front_right;
      s1_speed[2] <= speed_rear_left;
      s1_speed[3] <= speed_rear_right;
      // min speed compared against the sum, hence the factor of four
      s1_abs_on   <= abs_enable && (sum_in >= {abs_min_speed, 2'b00});
      s1_tcs_on   <= tcs_enable && (sum_in >= {tcs_min_speed, 2'b00});
    end
  end

  // stage 2: shared thresholds, four lanes, merge
  logic [wsm_pkg::THR_BITS-1:0] abs_thr;
  logic [wsm_pkg::THR_BITS-1:0] tcs_thr;
  wsm_pkg::lane_flags_t         lane_flags [wsm_pkg::NUM_WHEELS];
  wsm_pkg::merge_res_t          merged;

  assign abs_thr = wsm_pkg::THR_BITS'(s1_sum) * wsm_pkg::THR_BITS'(abs_slip_pct);
  assign tcs_thr = wsm_pkg::THR_BITS'(s1_sum) * wsm_pkg::THR_BITS'(tcs_slip_pct);

  for (genvar g = 0; g < wsm_pkg::NUM_WHEELS; g++) begin : g_lane
    wsm_lane u_lane (
      .speed   (s1_speed[g]),
      .sum     (s1_sum),
      .abs_thr (abs_thr),
      .tcs_thr (tcs_thr),
      .flags   (lane_flags[g])
    );
  end

  wsm_merge u_merge (
    .flags   (lane_flags),
    .abs_on  (s1_abs_on),
    .tcs_on  (s1_tcs_on),
    .abs_cnt (abs_events),
    .tcs_cnt (tcs_events),
    .res     (merged)
  );

  // output word and event counters
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      abs_events <= '0;
      tcs_events <= '0;
    end else begin
      if (out_load) begin
        out_valid  <= 1'b1;
        abs_events <= merged.abs_cnt_next;
        tcs_events <= merged.tcs_cnt_next;
      end else if (out_ready) begin
        out_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      lock_flag   <= |merged.abs_mask;
      lock_wheels <= merged.abs_mask;
      spin_flag   <= |merged.tcs_mask;
      spin_wheels <= merged.tcs_mask;
    end
  end

  // checks
  `WSM_ASSERT_IMPL(a_lock_flag_mask, out_valid, lock_flag == (lock_wheels != '0))
  `WSM_ASSERT_IMPL(a_no_lock_and_spin, out_valid, (lock_wheels & spin_wheels) == '0)
  `WSM_ASSERT_NEXT(a_cnt_hold, !out_load, $stable(abs_events) && $stable(tcs_events))
  `WSM_ASSERT_NEXT(a_abs_cnt_step, out_load,
                   (abs_events == $past(abs_events) + 32'd1) == lock_flag)

endmodule
